### rtl/two_class_sorted_priority_queue_defines.svh
// ----------------------------------------------------------------------------
// Two-class sorted priority queue: assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define TWO_CLASS_SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication.
`define TSPQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TSPQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tspq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspq_pkg
// Shared widths, opcodes and the types passed between the queue rows,
// their cells and the top level.
// ----------------------------------------------------------------------------
package tspq_pkg;

    localparam int KEY_W   = 16;
    localparam int TOTAL_W = 6;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic CLASS_FIRST  = 1'b0;
    localparam logic CLASS_SECOND = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             mark;
    } entry_t;

    typedef struct packed {
        logic   insert;
        logic   pop;
        entry_t entry;
    } row_cmd_t;

    typedef struct packed {
        logic   full;
        logic   empty;
        entry_t head;
    } row_stat_t;

endpackage

### rtl/tspq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspq_req_if
// Request channel: one insert or pop command per beat.
// ----------------------------------------------------------------------------
interface tspq_req_if;
    import tspq_pkg::*;

    logic             valid;
    logic             ready;
    logic             operation;
    logic             class_sel;
    logic [KEY_W-1:0] duration;
    logic             mark;

    modport source (
        output valid, operation, class_sel, duration, mark,
        input  ready
    );

    modport sink (
        input  valid, operation, class_sel, duration, mark,
        output ready
    );
endinterface

### rtl/tspq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspq_rsp_if
// Response channel: one result beat per request beat.
// ----------------------------------------------------------------------------
interface tspq_rsp_if;
    import tspq_pkg::*;

    logic               valid;
    logic               ready;
    logic               popped_valid;
    logic [KEY_W-1:0]   popped_duration;
    logic               popped_class;
    logic               popped_mark;
    logic               insert_accepted;
    logic [TOTAL_W-1:0] total_count;

    modport source (
        output valid, popped_valid, popped_duration, popped_class, popped_mark,
               insert_accepted, total_count,
        input  ready
    );

    modport sink (
        input  valid, popped_valid, popped_duration, popped_class, popped_mark,
               insert_accepted, total_count,
        output ready
    );
endinterface

### rtl/tspq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspq_cell
// One slot of a sorted row. Holds an entry, compares it with the key being
// inserted and takes the new entry, its left or its right neighbor.
// ----------------------------------------------------------------------------
module tspq_cell (
    input  logic              clk,
    input  tspq_pkg::row_cmd_t cmd,
    input  logic              occ,
    input  tspq_pkg::entry_t  left_entry,
    input  logic              left_b,
    input  tspq_pkg::entry_t  right_entry,
    output tspq_pkg::entry_t  entry,
    output logic              b
);
    import tspq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // set when the insert position is at or left of this slot
    assign b = !occ || (entry_reg.key > cmd.entry.key);

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.insert)
        begin
            if (left_b)
                entry_next = left_entry;
            else if (b)
                entry_next = cmd.entry;
        end
        else if (cmd.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
endmodule

### rtl/tspq_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspq_row
// One class queue: a row of cells kept in ascending key order, plus the
// fill count that marks which cells are occupied.
// ----------------------------------------------------------------------------
module tspq_row #(
    parameter  int DEPTH = 16,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tspq_pkg::row_cmd_t  cmd,
    output tspq_pkg::row_stat_t stat,
    output logic [CNT_W-1:0]    count
);
    import tspq_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    entry_t cell_entry [DEPTH];
    logic   cell_b     [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t left_entry;
        logic   left_b;
        entry_t right_entry;
        logic   occ;

        if (i == 0)
        begin : g_first
            assign left_entry = cmd.entry;
            assign left_b     = 1'b0;
        end
        else
        begin : g_mid
            assign left_entry = cell_entry[i-1];
            assign left_b     = cell_b[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        assign occ = CNT_W'(i) < count_reg;

        tspq_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .occ         (occ),
            .left_entry  (left_entry),
            .left_b      (left_b),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .b           (cell_b[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
            count_next = count_reg + 1'b1;
        else if (cmd.pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign stat.full  = count_reg == CNT_W'(DEPTH);
    assign stat.empty = count_reg == '0;
    assign stat.head  = cell_entry[0];
    assign count      = count_reg;
endmodule

### rtl/two_class_sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_sorted_priority_queue
// Two sorted queues, one per class, each a row of shifting cells.
//
// req carries one command per beat: insert (class_sel, duration, mark) or
// pop. rsp returns exactly one result beat per command, in order.
// An insert lands behind all stored entries of equal key in its class row;
// a full row refuses it and insert_accepted stays low. A pop takes the
// smaller head of the two rows, the second class on a tie; with both rows
// empty popped_valid is low.
// Each command is captured from its beat in the idle state; in the execute
// state every cell of the selected row shifts or loads in parallel and the
// result register loads, and the result is then visible on rsp. req.ready
// is low while a command executes, so a new beat waits until it is done.
// The result register holds until rsp.ready. While it is full and not taken,
// one more command beat is captured, then its shift cycle waits and
// req.ready stays low, so nothing is lost.
// Reset empties both rows (counts to zero) and drops any pending result.
// ----------------------------------------------------------------------------
module two_class_sorted_priority_queue #(
    parameter int QUEUE_CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    tspq_req_if.sink          req,
    tspq_rsp_if.source        rsp
);
    import tspq_pkg::*;

    `include "two_class_sorted_priority_queue_defines.svh"

    localparam int CNT_W = $clog2(QUEUE_CAPACITY + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    logic             op_reg;
    logic             cls_reg;
    logic [KEY_W-1:0] key_reg;
    logic             mark_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               pv_reg;
    logic [KEY_W-1:0]   pdur_reg;
    logic               pcls_reg;
    logic               pmark_reg;
    logic               acc_reg;
    logic [TOTAL_W-1:0] total_reg;

    row_cmd_t  cmd0;
    row_cmd_t  cmd1;
    row_stat_t stat0;
    row_stat_t stat1;
    logic [CNT_W-1:0] count0;
    logic [CNT_W-1:0] count1;

    logic go;
    logic do_ins;
    logic do_pop;
    logic ins0;
    logic ins1;
    logic have0;
    logic have1;
    logic sel0;
    logic pv;
    logic acc;
    logic [CNT_W:0] cnt_sum;
    logic [CNT_W:0] sum_after;

    assign req.ready = state_reg == ST_IDLE;

    assign go     = (state_reg == ST_EXEC) && (!out_valid_reg || rsp.ready);
    assign do_ins = go && (op_reg == OP_INSERT);
    assign do_pop = go && (op_reg == OP_POP);

    assign ins0  = do_ins && (cls_reg == CLASS_FIRST) && !stat0.full;
    assign ins1  = do_ins && (cls_reg == CLASS_SECOND) && !stat1.full;
    assign have0 = !stat0.empty;
    assign have1 = !stat1.empty;
    assign sel0  = have0 && (!have1 || (stat0.head.key < stat1.head.key));
    assign pv    = do_pop && (have0 || have1);
    assign acc   = ins0 || ins1;

    assign cmd0.insert     = ins0;
    assign cmd0.pop        = do_pop && sel0;
    assign cmd0.entry.key  = key_reg;
    assign cmd0.entry.mark = mark_reg;
    assign cmd1.insert     = ins1;
    assign cmd1.pop        = do_pop && have1 && !sel0;
    assign cmd1.entry.key  = key_reg;
    assign cmd1.entry.mark = mark_reg;

    tspq_row #(.DEPTH(QUEUE_CAPACITY)) u_row0 (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd0),
        .stat  (stat0),
        .count (count0)
    );

    tspq_row #(.DEPTH(QUEUE_CAPACITY)) u_row1 (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd1),
        .stat  (stat1),
        .count (count1)
    );

    assign cnt_sum   = (CNT_W+1)'(count0) + (CNT_W+1)'(count1);
    assign sum_after = cnt_sum + (CNT_W+1)'(acc) - (CNT_W+1)'(pv);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (go)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (go)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture the command beat
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg   <= req.operation;
            cls_reg  <= req.class_sel;
            key_reg  <= req.duration;
            mark_reg <= req.mark;
        end
    end

    // load the result beat
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            pv_reg    <= pv;
            pdur_reg  <= pv ? (sel0 ? stat0.head.key : stat1.head.key) : '0;
            pcls_reg  <= pv && !sel0;
            pmark_reg <= pv && (sel0 ? stat0.head.mark : stat1.head.mark);
            acc_reg   <= acc;
            total_reg <= TOTAL_W'(sum_after);
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.popped_valid    = pv_reg;
    assign rsp.popped_duration = pdur_reg;
    assign rsp.popped_class    = pcls_reg;
    assign rsp.popped_mark     = pmark_reg;
    assign rsp.insert_accepted = acc_reg;
    assign rsp.total_count     = total_reg;

    `TSPQ_ASSERT_NXT(a_accept_then_exec, req.valid && req.ready,
        state_reg == ST_EXEC && !req.ready, "accepted beat did not start execution")
    `TSPQ_ASSERT_IMP(a_count_bound,
        1'b1, count0 <= CNT_W'(QUEUE_CAPACITY) && count1 <= CNT_W'(QUEUE_CAPACITY),
        "row count above capacity")
    `TSPQ_ASSERT_NXT(a_insert_grows, go && acc,
        cnt_sum == $past(cnt_sum) + 1'b1, "accepted insert did not add one entry")
    `TSPQ_ASSERT_NXT(a_pop_shrinks, go && pv,
        cnt_sum == $past(cnt_sum) - 1'b1, "pop did not remove one entry")
    `TSPQ_ASSERT_IMP(a_result_exclusive, rsp.valid,
        !(rsp.popped_valid && rsp.insert_accepted), "result both popped and inserted")
endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-class sorted priority queue. Inserts and
// pops go in on the request channel and a scoreboard of expected result beats
// is built from an in-bench model of the two sorted rows. A short table of
// directed commands (empty pops, key extremes, ties, arrival order) comes
// first, then fill, drain and mixed bursts with random keys, under random
// idling on both channels and one long hold-off of the response channel.
// ----------------------------------------------------------------------------
module tb;
    import tspq_pkg::*;

    localparam int ROW_DEPTH   = 16;
    localparam int BURST_LEN   = 40;
    localparam int PHASE_ITEMS = 430;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_LIMIT = 2000;

    localparam int BURST_FILL  = 0;
    localparam int BURST_DRAIN = 1;
    localparam int BURST_EVEN  = 2;

    localparam int CLASS_MIXED = 2;

    typedef struct packed {
        logic               popped_valid;
        logic [KEY_W-1:0]   popped_duration;
        logic               popped_class;
        logic               popped_mark;
        logic               insert_accepted;
        logic [TOTAL_W-1:0] total_count;
    } pq_result_t;

    typedef struct packed {
        logic             operation;
        logic             class_sel;
        logic [KEY_W-1:0] duration;
        logic             mark;
        logic             fixed;
        pq_result_t       result;
    } cmd_row_t;

    logic clk;
    logic rst_n;

    tspq_req_if req_bus ();
    tspq_rsp_if rsp_bus ();

    two_class_sorted_priority_queue #(
        .QUEUE_CAPACITY(ROW_DEPTH)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_bus),
        .rsp  (rsp_bus)
    );

    entry_t     first_row[$];
    entry_t     second_row[$];
    pq_result_t pending_results[$];
    cmd_row_t   directed_rows[$];

    int src_idle_pct;
    int sink_idle_pct;
    bit stall_req;
    int hold_left;
    int err_count;

    initial begin
        clk = 1'b0;
    end

    always begin
        #5 clk = ~clk;
    end

    initial begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic pq_result_t make_result(input logic pv, input logic [KEY_W-1:0] pd,
                                               input logic pc, input logic pm,
                                               input logic acc, input int total);
        pq_result_t r;
        r.popped_valid    = pv;
        r.popped_duration = pd;
        r.popped_class    = pc;
        r.popped_mark     = pm;
        r.insert_accepted = acc;
        r.total_count     = total[TOTAL_W-1:0];
        return r;
    endfunction

    function automatic void sorted_insert(ref entry_t row[$], input entry_t e);
        int pos;
        pos = 0;
        while (pos < row.size() && row[pos].key <= e.key)
            pos++;
        row.insert(pos, e);
    endfunction

    function automatic pq_result_t queue_step(input logic op, input logic cls,
                                              input logic [KEY_W-1:0] dur, input logic mk);
        pq_result_t r;
        entry_t     e;
        logic       take_first;
        r = '0;
        if (op == OP_INSERT) begin
            e.key  = dur;
            e.mark = mk;
            if (cls == CLASS_FIRST && first_row.size() < ROW_DEPTH) begin
                sorted_insert(first_row, e);
                r.insert_accepted = 1'b1;
            end else if (cls == CLASS_SECOND && second_row.size() < ROW_DEPTH) begin
                sorted_insert(second_row, e);
                r.insert_accepted = 1'b1;
            end
        end else if (first_row.size() != 0 || second_row.size() != 0) begin
            take_first = first_row.size() != 0 &&
                         (second_row.size() == 0 || first_row[0].key < second_row[0].key);
            e = take_first ? first_row.pop_front() : second_row.pop_front();
            r.popped_valid    = 1'b1;
            r.popped_duration = e.key;
            r.popped_class    = take_first ? CLASS_FIRST : CLASS_SECOND;
            r.popped_mark     = e.mark;
        end
        r.total_count = TOTAL_W'(first_row.size() + second_row.size());
        return r;
    endfunction

    task automatic send_command(input logic op, input logic cls, input logic [KEY_W-1:0] dur,
                                input logic mk, input bit fixed, input pq_result_t fixed_res);
        pq_result_t r;
        while ($urandom_range(99) < src_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.operation <= op;
        req_bus.class_sel <= cls;
        req_bus.duration  <= dur;
        req_bus.mark      <= mk;
        do
            @(posedge clk);
        while (!req_bus.ready);
        r = queue_step(op, cls, dur, mk);
        pending_results.push_back(fixed ? fixed_res : r);
    endtask

    function automatic void add_row(input logic op, input logic cls,
                                    input logic [KEY_W-1:0] dur, input logic mk,
                                    input bit fixed, input pq_result_t r);
        cmd_row_t row;
        row.operation = op;
        row.class_sel = cls;
        row.duration  = dur;
        row.mark      = mk;
        row.fixed     = fixed;
        row.result    = r;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35)
            return KEY_W'($urandom_range(7));
        else if (roll < 45)
            return $urandom_range(1) ? {KEY_W{1'b1}} : '0;
        return KEY_W'($urandom_range(16'hFFFF));
    endfunction

    task automatic send_random(input int count);
        int   burst;
        int   class_bias;
        int   pop_pct;
        logic op;
        logic cls;
        for (int n = 0; n < count; n++) begin
            if (n % BURST_LEN == 0) begin
                burst      = (n == 0) ? BURST_FILL : $urandom_range(BURST_EVEN);
                class_bias = $urandom_range(CLASS_MIXED);
                pop_pct    = (burst == BURST_FILL) ? 20 : (burst == BURST_DRAIN) ? 80 : 50;
            end
            op = ($urandom_range(99) < pop_pct) ? OP_POP : OP_INSERT;
            if (class_bias == CLASS_MIXED || $urandom_range(99) < 15)
                cls = logic'($urandom_range(1));
            else
                cls = logic'(class_bias);
            send_command(op, cls, pick_key(), logic'($urandom_range(1)), 1'b0, '0);
        end
    endtask

    initial begin
        rsp_bus.ready <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (stall_req) begin
                hold_left = HOLD_CYCLES;
                stall_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        pq_result_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing pending");
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_bus.popped_valid !== want.popped_valid) begin
                    $error("popped_valid: expected %0d, actual %0d",
                           want.popped_valid, rsp_bus.popped_valid);
                    err_count++;
                end
                if (rsp_bus.popped_duration !== want.popped_duration) begin
                    $error("popped_duration: expected %0d, actual %0d",
                           want.popped_duration, rsp_bus.popped_duration);
                    err_count++;
                end
                if (rsp_bus.popped_class !== want.popped_class) begin
                    $error("popped_class: expected %0d, actual %0d",
                           want.popped_class, rsp_bus.popped_class);
                    err_count++;
                end
                if (rsp_bus.popped_mark !== want.popped_mark) begin
                    $error("popped_mark: expected %0d, actual %0d",
                           want.popped_mark, rsp_bus.popped_mark);
                    err_count++;
                end
                if (rsp_bus.insert_accepted !== want.insert_accepted) begin
                    $error("insert_accepted: expected %0d, actual %0d",
                           want.insert_accepted, rsp_bus.insert_accepted);
                    err_count++;
                end
                if (rsp_bus.total_count !== want.total_count) begin
                    $error("total_count: expected %0d, actual %0d",
                           want.total_count, rsp_bus.total_count);
                    err_count++;
                end
            end
        end
    end

    initial begin
        int       waited;
        cmd_row_t row;
        err_count         = 0;
        stall_req         = 1'b0;
        src_idle_pct      = 30;
        sink_idle_pct     = 51;
        rst_n             <= 1'b0;
        req_bus.valid     <= 1'b0;
        req_bus.operation <= OP_INSERT;
        req_bus.class_sel <= CLASS_FIRST;
        req_bus.duration  <= '0;
        req_bus.mark      <= 1'b0;

        add_row(OP_POP,    CLASS_FIRST,  16'h0000, 1'b0, 1'b1, make_result(0, 0, 0, 0, 0, 0));
        add_row(OP_POP,    CLASS_SECOND, 16'hFFFF, 1'b1, 1'b1, make_result(0, 0, 0, 0, 0, 0));
        add_row(OP_INSERT, CLASS_FIRST,  16'hFFFF, 1'b1, 1'b1, make_result(0, 0, 0, 0, 1, 1));
        add_row(OP_INSERT, CLASS_SECOND, 16'h0000, 1'b0, 1'b1, make_result(0, 0, 0, 0, 1, 2));
        add_row(OP_POP,    CLASS_FIRST,  16'h0000, 1'b0, 1'b1,
                make_result(1, 16'h0000, CLASS_SECOND, 0, 0, 1));
        add_row(OP_POP,    CLASS_FIRST,  16'h0000, 1'b0, 1'b1,
                make_result(1, 16'hFFFF, CLASS_FIRST, 1, 0, 0));
        add_row(OP_POP,    CLASS_SECOND, 16'h5555, 1'b1, 1'b1, make_result(0, 0, 0, 0, 0, 0));
        add_row(OP_INSERT, CLASS_FIRST,  16'd100,  1'b0, 1'b0, '0);
        add_row(OP_INSERT, CLASS_SECOND, 16'd100,  1'b1, 1'b0, '0);
        add_row(OP_INSERT, CLASS_FIRST,  16'd100,  1'b1, 1'b0, '0);
        add_row(OP_INSERT, CLASS_SECOND, 16'd100,  1'b0, 1'b0, '0);
        add_row(OP_POP,    CLASS_FIRST,  16'h0000, 1'b0, 1'b0, '0);
        add_row(OP_POP,    CLASS_FIRST,  16'h0000, 1'b0, 1'b0, '0);
        add_row(OP_POP,    CLASS_FIRST,  16'h0000, 1'b0, 1'b0, '0);
        add_row(OP_POP,    CLASS_FIRST,  16'h0000, 1'b0, 1'b0, '0);
        add_row(OP_INSERT, CLASS_SECOND, 16'h8000, 1'b0, 1'b0, '0);
        add_row(OP_INSERT, CLASS_FIRST,  16'h7FFF, 1'b1, 1'b0, '0);
        add_row(OP_INSERT, CLASS_FIRST,  16'h8001, 1'b0, 1'b0, '0);
        add_row(OP_INSERT, CLASS_FIRST,  16'h7FFF, 1'b0, 1'b0, '0);
        add_row(OP_POP,    CLASS_SECOND, 16'hAAAA, 1'b1, 1'b0, '0);
        add_row(OP_POP,    CLASS_FIRST,  16'h0000, 1'b0, 1'b0, '0);
        add_row(OP_POP,    CLASS_FIRST,  16'h0000, 1'b0, 1'b0, '0);
        add_row(OP_POP,    CLASS_FIRST,  16'h0000, 1'b0, 1'b0, '0);
        add_row(OP_POP,    CLASS_FIRST,  16'h0000, 1'b0, 1'b0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_command(row.operation, row.class_sel, row.duration, row.mark,
                         row.fixed, row.result);
        end
        send_random(PHASE_ITEMS);

        src_idle_pct  = 51;
        sink_idle_pct = 30;
        send_random(PHASE_ITEMS);

        // hold the response side while requests keep coming
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        stall_req     = 1'b1;
        send_random(PHASE_ITEMS);
        req_bus.valid <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);

        if (pending_results.size() != 0) begin
            $error("%0d result beats never arrived", pending_results.size());
            err_count++;
        end

        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
